[rtl/core/sacl_pkg.sv]
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and constants of the cache tag directory.
// ----------------------------------------------------------------------------
package sacl_pkg;

  localparam int TAG_W    = 32;
  localparam int DATA_W   = 32;
  localparam int PADDR_W  = 4;

  // register byte addresses
  localparam logic [PADDR_W-1:0] REG_BLOCK_LOG = 4'h0;
  localparam logic [PADDR_W-1:0] REG_SETS_LOG  = 4'h4;
  localparam logic [PADDR_W-1:0] REG_WAYS_LOG  = 4'h8;
  localparam logic [PADDR_W-1:0] REG_WR_ALLOC  = 4'hC;

  localparam logic [3:0] BLOCK_LOG_MAX = 4'd10;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  typedef struct packed {
    logic              hit;
    logic              evicted;
    logic              evicted_dirty;
    logic [DATA_W-1:0] evicted_address;
  } result_t;

endpackage

[rtl/core/sacl_tag_ram.sv]
// ----------------------------------------------------------------------------
// sacl_tag_ram
// One-port-write, one-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module sacl_tag_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/sacl_update.sv]
// ----------------------------------------------------------------------------
// sacl_update
// Set lookup: hit detect, free/victim pick, LRU aging and row rewrite.
// ----------------------------------------------------------------------------
module sacl_update
  import sacl_pkg::*;
#(
  parameter int MAX_WAYS = 8,
  parameter int AGE_W    = 3,
  parameter int WL_W     = 3,
  parameter int ROW_W    = 8
) (
  input  logic [ROW_W-1:0] row_in,
  input  logic [TAG_W-1:0] tag,
  input  logic [31:0]      set_bits,   // set index already shifted into place
  input  logic             wr,
  input  logic             wr_alloc,
  input  logic [WL_W-1:0]  nways,
  input  logic [4:0]       tag_shift,
  output logic             we,
  output logic [ROW_W-1:0] row_out,
  output result_t          res
);

  localparam int ENT_W = TAG_W + AGE_W + 2;
  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);

  logic [MAX_WAYS-1:0] v, d, in_use;
  logic [AGE_W-1:0]    age [MAX_WAYS];
  logic [TAG_W-1:0]    tg  [MAX_WAYS];
  logic [MAX_WAYS-1:0] is_tgt;

  logic             hit_f, free_f, vic_f, fill;
  logic [AGE_W-1:0] hit_age, vic_age, below;
  logic [TAG_W-1:0] vic_tag;
  logic             vic_dirty;
  logic [MAX_WAYS-1:0] hit_oh, free_oh, vic_oh;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      v[w]      = row_in[w*ENT_W];
      d[w]      = row_in[w*ENT_W + 1];
      age[w]    = row_in[w*ENT_W + 2 +: AGE_W];
      tg[w]     = row_in[w*ENT_W + 2 + AGE_W +: TAG_W];
      in_use[w] = (WL_W'(w) < nways);
    end
  end

  // priority scans over the ways in use
  always_comb begin
    hit_f = 1'b0; free_f = 1'b0; vic_f = 1'b0;
    hit_age = '0; vic_age = '0; vic_tag = '0; vic_dirty = 1'b0;
    hit_oh = '0; free_oh = '0; vic_oh = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (in_use[w]) begin
        if (v[w]) begin
          if (!hit_f && tg[w] == tag) begin
            hit_f = 1'b1; hit_age = age[w]; hit_oh = '0; hit_oh[w] = 1'b1;
          end
          if (!vic_f || age[w] > vic_age) begin
            vic_f = 1'b1; vic_age = age[w]; vic_tag = tg[w]; vic_dirty = d[w];
            vic_oh = '0; vic_oh[w] = 1'b1;
          end
        end else if (!free_f) begin
          free_f = 1'b1; free_oh = '0; free_oh[w] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    fill   = !hit_f && !(wr && !wr_alloc);
    we     = hit_f || fill;
    is_tgt = hit_f ? hit_oh : (free_f ? free_oh : vic_oh);
    below  = hit_f ? hit_age : vic_age;
    row_out = row_in;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (in_use[w] && v[w] && age[w] < AGE_MAX &&
          ((!hit_f && free_f) || age[w] < below)) begin
        row_out[w*ENT_W + 2 +: AGE_W] = age[w] + AGE_W'(1);
      end
      if (is_tgt[w]) begin
        row_out[w*ENT_W + 2 +: AGE_W] = '0;
        if (hit_f) begin
          row_out[w*ENT_W + 1] = d[w] | wr;
        end else begin
          row_out[w*ENT_W]     = 1'b1;
          row_out[w*ENT_W + 1] = wr;
          row_out[w*ENT_W + 2 + AGE_W +: TAG_W] = tag;
        end
      end
    end
  end

  always_comb begin
    res = '0;
    res.hit = hit_f;
    if (fill && !free_f) begin
      res.evicted         = 1'b1;
      res.evicted_dirty   = vic_dirty;
      res.evicted_address = (vic_tag << tag_shift) | set_bits;
    end
  end

endmodule

[rtl/core/set_assoc_cache_tag_lru_core.sv]
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lru_core
// Tag directory of a set-associative write-back cache with true LRU.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel: address/is_write with in_valid/in_ready. Response
//    channel: hit/evicted/evicted_dirty/evicted_address with
//    out_valid/out_ready. One response per request, in order.
//  - APB port sets block_log (0x0), sets_log (0x4), ways_log (0x8) and
//    write_allocate (0xC); write only while idle.
//  - Flow: a request accepted in the idle state reads its set row from the
//    tag RAM; in the lookup state that follows, the row is compared, aged and
//    written back and the response is registered. A new request is only
//    taken once that read-modify-write of the set row is done.
//  - All ways of a set sit in one RAM row; the next request is only taken
//    after the write back, so no forwarding is needed.
//  - Reset: registers go to their defaults, then a clearing pass writes
//    MAX_SETS rows (one per cycle) before in_ready rises.
//  - Stall: the response is held in an output register; a new request is
//    taken while the last response is being taken, so a stalled receiver
//    holds off in_ready.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_lru_core
  import sacl_pkg::*;
#(
  parameter int MAX_SETS  = 64,
  parameter int MAX_WAYS  = 8,
  parameter int ADDR_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  // APB config
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  // request
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        address,
  input  logic               is_write,
  // response
  output logic               out_valid,
  input  logic               out_ready,
  output logic               hit,
  output logic               evicted,
  output logic               evicted_dirty,
  output logic [31:0]        evicted_address
);

  // floor(log2) of the sizes: sets/ways in use never exceed these
  localparam int SET_LOG = $clog2(MAX_SETS + 1) - 1;
  localparam int WAY_LOG = $clog2(MAX_WAYS + 1) - 1;
  localparam int SET_AW  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int AGE_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WL_W    = $clog2(MAX_WAYS + 1) + 1;
  localparam int ENT_W   = TAG_W + AGE_W + 2;
  localparam int ROW_W   = ENT_W * MAX_WAYS;
  localparam logic [31:0] ADDR_MASK =
    (ADDR_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << ADDR_BITS) - 32'd1);
  localparam logic [SET_AW-1:0] LAST_ROW = SET_AW'(MAX_SETS - 1);

  // config registers
  logic [3:0] block_log;
  logic [2:0] sets_log;
  logic [1:0] ways_log;
  logic       write_allocate;

  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_log      <= 4'd5;
      sets_log       <= 3'd6;
      ways_log       <= 2'd2;
      write_allocate <= 1'b1;
    end else if (cfg_wr) begin
      case (paddr)
        REG_BLOCK_LOG: block_log      <= pwdata[3:0];
        REG_SETS_LOG:  sets_log       <= pwdata[2:0];
        REG_WAYS_LOG:  ways_log       <= pwdata[1:0];
        REG_WR_ALLOC:  write_allocate <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      REG_BLOCK_LOG: prdata = {28'd0, block_log};
      REG_SETS_LOG:  prdata = {29'd0, sets_log};
      REG_WAYS_LOG:  prdata = {30'd0, ways_log};
      REG_WR_ALLOC:  prdata = {31'd0, write_allocate};
      default:       prdata = '0;
    endcase
  end

  // effective geometry: saturate to what the storage holds
  logic [3:0]      bl;
  logic [2:0]      sl;
  logic [1:0]      wl;
  logic [4:0]      tag_shift;
  logic [WL_W-1:0] nways;

  always_comb begin
    bl = (block_log > BLOCK_LOG_MAX) ? BLOCK_LOG_MAX : block_log;
    sl = (SET_LOG < 7 && sets_log > 3'(SET_LOG)) ? 3'(SET_LOG) : sets_log;
    wl = (WAY_LOG < 3 && ways_log > 2'(WAY_LOG)) ? 2'(WAY_LOG) : ways_log;
    tag_shift = 5'(bl) + 5'(sl);
    nways = WL_W'(1) << wl;
  end

  // address split at accept
  logic [31:0]       addr_m, set_full;
  logic [SET_AW-1:0] set_idx;
  logic [TAG_W-1:0]  tag_in;

  always_comb begin
    addr_m   = address & ADDR_MASK;
    set_full = (addr_m >> bl) & ((32'd1 << sl) - 32'd1);
    set_idx  = SET_AW'(set_full);
    tag_in   = addr_m >> tag_shift;
  end

  // control
  state_t state, state_next;
  logic [SET_AW-1:0] clr_idx;
  logic [SET_AW-1:0] set_q;
  logic [31:0]       set_bits_q;
  logic [TAG_W-1:0]  tag_q;
  logic              wr_q;
  logic              accept;

  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (clr_idx == LAST_ROW) state_next = ST_IDLE;
      ST_IDLE:   if (accept) state_next = ST_LOOKUP;
      ST_LOOKUP: state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + SET_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      set_q      <= set_idx;
      set_bits_q <= set_full << bl;
      tag_q      <= tag_in;
      wr_q       <= is_write;
    end
  end

  // tag RAM: one row per set, all ways side by side
  logic              ram_we, upd_we;
  logic [SET_AW-1:0] ram_waddr;
  logic [ROW_W-1:0]  ram_wdata, row_rd, row_new;
  result_t           res;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = set_q;
    ram_wdata = row_new;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx;
        ram_wdata = '0;
      end
      ST_LOOKUP: ram_we = upd_we;
      default: ;
    endcase
  end

  sacl_tag_ram #(
    .DEPTH (MAX_SETS),
    .WIDTH (ROW_W),
    .AW    (SET_AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (set_idx),
    .rdata (row_rd)
  );

  sacl_update #(
    .MAX_WAYS (MAX_WAYS),
    .AGE_W    (AGE_W),
    .WL_W     (WL_W),
    .ROW_W    (ROW_W)
  ) u_upd (
    .row_in    (row_rd),
    .tag       (tag_q),
    .set_bits  (set_bits_q),
    .wr        (wr_q),
    .wr_alloc  (write_allocate),
    .nways     (nways),
    .tag_shift (tag_shift),
    .we        (upd_we),
    .row_out   (row_new),
    .res       (res)
  );

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_LOOKUP) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOOKUP) begin
      hit             <= res.hit;
      evicted         <= res.evicted;
      evicted_dirty   <= res.evicted_dirty;
      evicted_address <= res.evicted_address;
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cache tag directory: a local LRU tag model
// predicts hit/evict/dirty/address per request, a scoreboard compares each
// response in order. APB writes between phases sweep block, set and way
// sizes and write allocate.
// ----------------------------------------------------------------------------

class cache_scoreboard;
  localparam int NSETS = 64;
  localparam int NWAYS = 8;

  bit [31:0] tags [NSETS*NWAYS];
  bit        vld  [NSETS*NWAYS];
  bit        dty  [NSETS*NWAYS];
  int        age  [NSETS*NWAYS];
  int        blk_log, set_log, way_log;
  bit        wr_alloc;
  sacl_pkg::result_t pending [$];
  int        errors;

  function new();
    blk_log = 5; set_log = 6; way_log = 2; wr_alloc = 1; errors = 0;
    foreach (vld[i]) begin
      tags[i] = 0; vld[i] = 0; dty[i] = 0; age[i] = 0;
    end
  endfunction

  // bump every valid way in the set whose age is below the limit
  function void age_set(int base, int nways, int lim);
    for (int w = 0; w < nways; w++)
      if (vld[base+w] && age[base+w] < lim && age[base+w] < NWAYS - 1)
        age[base+w]++;
  endfunction

  // note an accepted request and queue the response it must produce
  function void note_request(bit [31:0] addr, bit wr);
    sacl_pkg::result_t r;
    int bl, sl, wl, nways, set_idx, base, hw, fw, vw, e;
    bit [31:0] tg;
    bl = blk_log > 10 ? 10 : blk_log;
    sl = set_log > 6 ? 6 : set_log;
    wl = way_log > 3 ? 3 : way_log;
    nways = 1 << wl;
    set_idx = (addr >> bl) & ((1 << sl) - 1);
    tg = addr >> (bl + sl);
    base = set_idx * NWAYS;
    hw = -1; fw = -1; vw = -1;
    r = '0;
    for (int w = 0; w < nways; w++) begin
      e = base + w;
      if (vld[e]) begin
        if (hw < 0 && tags[e] == tg) hw = w;
        if (vw < 0 || age[e] > age[base+vw]) vw = w;
      end else if (fw < 0) begin
        fw = w;
      end
    end
    if (hw >= 0) begin
      e = base + hw;
      age_set(base, nways, age[e]);
      age[e] = 0;
      if (wr) dty[e] = 1;
      r.hit = 1;
    end else if (!(wr && !wr_alloc)) begin
      if (fw >= 0) begin
        e = base + fw;
        age_set(base, nways, 1000);
      end else begin
        e = base + vw;
        r.evicted = 1;
        r.evicted_dirty = dty[e];
        r.evicted_address =
          32'((64'(tags[e]) << (bl + sl)) | (64'(set_idx) << bl));
        age_set(base, nways, age[e]);
      end
      tags[e] = tg; vld[e] = 1; dty[e] = wr; age[e] = 0;
    end
    pending.insert(pending.size(), r);
  endfunction

  function void check_response(sacl_pkg::result_t got);
    sacl_pkg::result_t exp;
    if (pending.size() == 0) begin
      $display("%0t: unexpected response %p", $time, got);
      errors++;
      return;
    end
    exp = pending[0];
    pending.delete(0);
    if (got.hit !== exp.hit) begin
      $display("%0t: hit exp %0b got %0b", $time, exp.hit, got.hit); errors++;
    end
    if (got.evicted !== exp.evicted) begin
      $display("%0t: evicted exp %0b got %0b", $time, exp.evicted, got.evicted);
      errors++;
    end
    if (got.evicted_dirty !== exp.evicted_dirty) begin
      $display("%0t: evicted_dirty exp %0b got %0b", $time, exp.evicted_dirty,
               got.evicted_dirty);
      errors++;
    end
    if (got.evicted_address !== exp.evicted_address) begin
      $display("%0t: evicted_address exp %h got %h", $time, exp.evicted_address,
               got.evicted_address);
      errors++;
    end
  endfunction
endclass

module tb_top;
  import sacl_pkg::*;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_ready, is_write;
  logic [31:0] address;
  logic out_valid, out_ready, hit, evicted, evicted_dirty;
  logic [31:0] evicted_address;

  cache_scoreboard sb;
  int send_idle_pct, recv_idle_pct;
  bit recv_hold;      // long receiver stall request
  int quiet_cycles;
  bit timed_out;
  // recent addresses, reused to get hits and evictions
  logic [31:0] hot_addrs [$];

  set_assoc_cache_tag_lru_core DUT (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // response side: random back-pressure plus an optional long hold
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready)
        sb.check_response('{hit, evicted, evicted_dirty, evicted_address});
      out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog: cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)
        || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  always @(posedge clk)
    if (quiet_cycles > 5000 && !timed_out) begin
      timed_out = 1;
      $display("Testbench completed WITH ERRORS");
      $finish;
    end

  // psel stays up between back-to-back writes; configure drops it
  task automatic apb_write(logic [PADDR_W-1:0] a, int v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= a; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (a)
      REG_BLOCK_LOG: sb.blk_log  = v;
      REG_SETS_LOG:  sb.set_log  = v;
      REG_WAYS_LOG:  sb.way_log  = v;
      default:       sb.wr_alloc = v[0];
    endcase
  endtask

  // send one request, holding valid until taken; valid stays up after the
  // accept so the next request can follow at once, drain drops it
  task automatic send_request(logic [31:0] a, logic w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; address <= a; is_write <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(a, w);
    hot_addrs.insert(hot_addrs.size(), a);
    if (hot_addrs.size() > 24) hot_addrs.delete(0);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic configure(int bl, int sl, int wl, int wa);
    drain();
    apb_write(REG_BLOCK_LOG, bl);
    apb_write(REG_SETS_LOG, sl);
    apb_write(REG_WAYS_LOG, wl);
    apb_write(REG_WR_ALLOC, wa);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // mostly reuse of nearby/recent blocks so hits and evictions are common
  task automatic random_requests(int n);
    logic [31:0] a;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: a = $urandom();
        1: a = hot_addrs.size() ? hot_addrs[$urandom_range(hot_addrs.size()-1)]
                                : $urandom();
        default: a = (32'($urandom_range(7)) << 12) | ($urandom() & 32'h0000_0FFF)
                     | ($urandom_range(1) ? 32'hFFFF_0000 : 32'h0);
      endcase
      send_request(a, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    sb = new();
    timed_out = 0;
    rst = 1; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid = 0; address = '0; is_write = 0;
    recv_hold = 0; send_idle_pct = 0; recv_idle_pct = 0;
    repeat (7) @(posedge clk);
    rst <= 0;

    // directed: default config, fill a set, hit, evict dirty, extremes
    send_request(32'h0000_0000, 0);
    send_request(32'hFFFF_FFFF, 1);
    send_request(32'h0000_0000, 1);           // write hit marks dirty
    for (int k = 1; k <= 4; k++) send_request(k << 11, 0); // evict dirty line
    send_request(32'hFFFF_FFFF, 0);
    configure(0, 0, 0, 0);                     // 1 way, fully associative
    send_request(32'h1234_5678, 1);           // write miss, no allocate
    send_request(32'h1234_5678, 0);
    send_request(32'h1234_5679, 1);           // write miss, no allocate
    send_request(32'h1234_5678, 0);           // read hit
    configure(15, 7, 3, 1);                    // saturated sizes
    send_request(32'hAAAA_AAAA, 1);
    send_request(32'h5555_5555, 0);
    for (int k = 0; k < 9; k++) send_request(k << 16, k[0]);
    send_request(32'h0000_0000, 0);

    // phase 1: sender seldom idles, receiver mostly stalls
    send_idle_pct = 9; recv_idle_pct = 88;
    configure(2, 1, 1, 1);
    random_requests(150);
    // long receiver hold while requests keep coming
    fork
      begin
        recv_hold = 1;
        repeat (300) @(posedge clk);
        recv_hold = 0;
      end
      random_requests(20);
    join
    // phase 2: the other way round
    send_idle_pct = 88; recv_idle_pct = 9;
    configure(10, 0, 3, 0);
    random_requests(150);
    // sender pauses until everything is back
    drain();
    // phase 3: no idling
    send_idle_pct = 0; recv_idle_pct = 0;
    configure(4, 3, 2, 1);
    random_requests(150);
    configure(6, 2, 3, 0);
    random_requests(150);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
